/* src/frame_flip_rotate_invert_assert.svh */
// Assertion macros for the frame orientation engine.
// Used by the top level; needs clk_i and rst_ni in scope.
`ifndef FRAME_FLIP_ROTATE_INVERT_ASSERT_SVH
`define FRAME_FLIP_ROTATE_INVERT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define FFRI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FFRI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ffri_pkg.sv */
// Shared types and constants of the frame orientation engine.
// Used by ffri_ctrl, ffri_dp and frame_flip_rotate_invert.
`timescale 1ns / 1ps
`default_nettype none

package ffri_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PixW     = 3 * ByteW;
  localparam int unsigned DimRegW  = 9;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  // Transform select codes
  localparam logic [ModeW-1:0] MODE_INVERT = 3'd0;
  localparam logic [ModeW-1:0] MODE_HFLIP  = 3'd1;
  localparam logic [ModeW-1:0] MODE_VFLIP  = 3'd2;
  localparam logic [ModeW-1:0] MODE_CW     = 3'd3;
  localparam logic [ModeW-1:0] MODE_CCW    = 3'd4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_COLOR  = 2'd3;

  localparam logic [DimRegW-1:0] DIM_RESET = 9'd256;

  // Input action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic load;   // store one pixel, advance load counters
    logic fetch;  // issue store read, advance output counters
    logic resp;   // fill the output register
  } cmd_t;

endpackage

`default_nettype wire

/* src/ffri_ctrl.sv */
// Controller of the frame orientation engine: handshake and result slot.
// Depends on ffri_pkg; drives the command struct of ffri_dp.
`timescale 1ns / 1ps
`default_nettype none

module ffri_ctrl import ffri_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic action_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (action_i == ACT_FETCH)) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    cmd_o.load  = accept && (action_i == ACT_LOAD);
    cmd_o.fetch = accept && (action_i == ACT_FETCH);
    cmd_o.resp  = (state_q == ST_RESP) && slot_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.resp) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* src/ffri_dp.sv */
// Datapath of the frame orientation engine: registers, counters, frame store,
// address mapping and output register. Depends on ffri_pkg; driven by ffri_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ffri_dp import ffri_pkg::*; #(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [ByteW-1:0]    in_first_i,
  input  logic [ByteW-1:0]    in_second_i,
  input  logic [ByteW-1:0]    in_third_i,
  output logic [ByteW-1:0]    out_first_o,
  output logic [ByteW-1:0]    out_second_o,
  output logic [ByteW-1:0]    out_third_o,
  output logic                last_pixel_o,
  output logic                status_o
);

  localparam int unsigned DimW  = $clog2(MAX_DIM + 1);
  localparam int unsigned CmpW  = (DimW > DimRegW) ? DimW : DimRegW;
  localparam int unsigned Depth = MAX_DIM * MAX_DIM;
  localparam int unsigned AddrW = $clog2(Depth);

  function automatic logic [DimW-1:0] eff_dim(input logic [DimRegW-1:0] v);
    logic [CmpW-1:0] vx;
    vx = CmpW'(v);
    if (v == '0) begin
      eff_dim = DimW'(1);
    end else if (vx > CmpW'(MAX_DIM)) begin
      eff_dim = DimW'(MAX_DIM);
    end else begin
      eff_dim = DimW'(vx);
    end
  endfunction

  function automatic logic [AddrW-1:0] store_addr(input logic [DimW-1:0] row,
                                                  input logic [DimW-1:0] col);
    logic [AddrW-1:0] row_a;
    row_a = AddrW'(row);
    store_addr = AddrW'(row_a * AddrW'(MAX_DIM)) + AddrW'(col);
  endfunction

  // Configuration registers
  logic [ModeW-1:0]   mode_q;
  logic [DimRegW-1:0] width_q, height_q;
  logic               rgb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_INVERT;
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
      rgb_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:   mode_q   <= cfg_data_i[ModeW-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[DimRegW-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[DimRegW-1:0];
        CFG_COLOR:  rgb_q    <= cfg_data_i[0];
      endcase
    end
  end

  // Counters
  logic [DimW-1:0] load_row_q, load_row_d, load_col_q, load_col_d;
  logic [DimW-1:0] out_outer_q, out_outer_d, out_inner_q, out_inner_d;
  logic            loaded_q, loaded_d;

  logic [DimW-1:0] w, h, outer_lim, inner_lim, o, i, r, c;
  logic [ModeW-1:0] m;
  logic            rot;
  logic [DimW:0]   inner_nx, outer_nx, col_nx, row_nx;
  logic            inner_wrap, frame_end, col_wrap, in_bounds;
  logic            wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [PixW-1:0]  wr_data;

  assign w   = eff_dim(width_q);
  assign h   = eff_dim(height_q);
  assign m   = (mode_q <= MODE_CCW) ? mode_q : MODE_INVERT;
  assign rot = (m == MODE_CW) || (m == MODE_CCW);

  assign outer_lim = rot ? w : h;
  assign inner_lim = rot ? h : w;
  // Clamp counters left beyond the bounds by a register change
  assign o = (out_outer_q < outer_lim) ? out_outer_q : outer_lim - DimW'(1);
  assign i = (out_inner_q < inner_lim) ? out_inner_q : inner_lim - DimW'(1);

  always_comb begin
    unique case (m)
      MODE_HFLIP: begin r = o;                  c = w - DimW'(1) - i; end
      MODE_VFLIP: begin r = h - DimW'(1) - o;   c = i;                end
      MODE_CW:    begin r = h - DimW'(1) - i;   c = o;                end
      MODE_CCW:   begin r = i;                  c = w - DimW'(1) - o; end
      default:    begin r = o;                  c = i;                end
    endcase
  end

  assign inner_nx   = {1'b0, i} + (DimW+1)'(1);
  assign outer_nx   = {1'b0, o} + (DimW+1)'(1);
  assign inner_wrap = inner_nx >= {1'b0, inner_lim};
  assign frame_end  = inner_wrap && (outer_nx >= {1'b0, outer_lim});

  assign col_nx    = {1'b0, load_col_q} + (DimW+1)'(1);
  assign row_nx    = {1'b0, load_row_q} + (DimW+1)'(1);
  assign col_wrap  = col_nx >= {1'b0, w};
  assign in_bounds = (load_row_q < h) && (load_col_q < w);

  assign wr_en   = cmd_i.load && !loaded_q && in_bounds;
  assign rd_en   = cmd_i.fetch && loaded_q;
  assign wr_addr = store_addr(load_row_q, load_col_q);
  assign rd_addr = store_addr(r, c);
  assign wr_data = {rgb_q ? in_third_i  : {ByteW{1'b0}},
                    rgb_q ? in_second_i : {ByteW{1'b0}},
                    in_first_i};

  always_comb begin
    load_row_d  = load_row_q;
    load_col_d  = load_col_q;
    out_outer_d = out_outer_q;
    out_inner_d = out_inner_q;
    loaded_d    = loaded_q;
    if (cmd_i.load && !loaded_q) begin
      if (col_wrap) begin
        load_col_d = '0;
        load_row_d = DimW'(row_nx);
        if (row_nx >= {1'b0, h}) loaded_d = 1'b1;
      end else begin
        load_col_d = DimW'(col_nx);
      end
    end
    if (rd_en) begin
      priority if (frame_end) begin
        // restart everything for the next frame
        load_row_d  = '0;
        load_col_d  = '0;
        out_outer_d = '0;
        out_inner_d = '0;
        loaded_d    = 1'b0;
      end else if (inner_wrap) begin
        out_inner_d = '0;
        out_outer_d = DimW'(outer_nx);
      end else begin
        out_inner_d = DimW'(inner_nx);
        out_outer_d = o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_row_q  <= '0;
      load_col_q  <= '0;
      out_outer_q <= '0;
      out_inner_q <= '0;
      loaded_q    <= 1'b0;
    end else begin
      load_row_q  <= load_row_d;
      load_col_q  <= load_col_d;
      out_outer_q <= out_outer_d;
      out_inner_q <= out_inner_d;
      loaded_q    <= loaded_d;
    end
  end

  // Frame store, registered read
  logic [PixW-1:0] store_mem [Depth];
  logic [PixW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) store_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= store_mem[rd_addr];
  end

  // Beat attributes captured at fetch
  logic resp_status_q, resp_last_q, resp_inv_q, resp_rgb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      resp_status_q <= !loaded_q;
      resp_last_q   <= loaded_q && frame_end;
      resp_inv_q    <= (m == MODE_INVERT);
      resp_rgb_q    <= rgb_q;
    end
  end

  // Output register, held while the receiver stalls
  logic [PixW-1:0]  px;
  logic [ByteW-1:0] out_first_q, out_second_q, out_third_q;
  logic             last_q, status_q;

  assign px = resp_inv_q ? ~rd_data_q : rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) begin
      if (resp_status_q) begin
        out_first_q  <= '0;
        out_second_q <= '0;
        out_third_q  <= '0;
        last_q       <= 1'b0;
        status_q     <= 1'b1;
      end else begin
        out_first_q  <= px[ByteW-1:0];
        out_second_q <= resp_rgb_q ? px[2*ByteW-1:ByteW] : {ByteW{1'b0}};
        out_third_q  <= resp_rgb_q ? px[3*ByteW-1:2*ByteW] : {ByteW{1'b0}};
        last_q       <= resp_last_q;
        status_q     <= 1'b0;
      end
    end
  end

  assign out_first_o  = out_first_q;
  assign out_second_o = out_second_q;
  assign out_third_o  = out_third_q;
  assign last_pixel_o = last_q;
  assign status_o     = status_q;

endmodule

`default_nettype wire

/* src/frame_flip_rotate_invert.sv */
// Frame orientation engine: a frame store loaded in raster order and read back
// inverted, mirrored or rotated by 90 degrees.
// A load beat returns nothing. For a fetch beat the store address is formed
// and the read issued in the accept cycle, and the registered read data fills
// the output register once that register is free. A result then waits in the
// output register while the receiver stalls it; the block holds in_ready_o low
// from a fetch until its result has entered the output register, so at most
// one fetch is in flight.
// Loads past the frame size are ignored. A fetch before the frame is fully
// loaded returns zero data with status_o set. last_pixel_o marks the final
// pixel of the transformed frame, after which a new frame may be loaded.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once;
// the user must make them only while no beat is in flight, as the block has no check.
// Reset clears the registers to mode invert, 256 x 256, gray, and clears all
// counters; the store contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module frame_flip_rotate_invert import ffri_pkg::*; #(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  input  logic [ByteW-1:0]    in_first_i,
  input  logic [ByteW-1:0]    in_second_i,
  input  logic [ByteW-1:0]    in_third_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ByteW-1:0]    out_first_o,
  output logic [ByteW-1:0]    out_second_o,
  output logic [ByteW-1:0]    out_third_o,
  output logic                last_pixel_o,
  output logic                status_o
);

  cmd_t cmd;

  ffri_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  ffri_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_first_i   (in_first_i),
    .in_second_i  (in_second_i),
    .in_third_i   (in_third_i),
    .out_first_o  (out_first_o),
    .out_second_o (out_second_o),
    .out_third_o  (out_third_o),
    .last_pixel_o (last_pixel_o),
    .status_o     (status_o)
  );

`include "frame_flip_rotate_invert_assert.svh"

  `FFRI_ASSERT_NEXT(a_fetch_blocks_input, in_valid_i && in_ready_o && (action_i == ACT_FETCH), !in_ready_o, "fetch beat did not hold off input")
  `FFRI_ASSERT_NEXT(a_load_no_result, in_valid_i && in_ready_o && (action_i == ACT_LOAD) && !out_valid_o, !out_valid_o, "load beat produced a result")
  `FFRI_ASSERT_NOW(a_status_not_last, out_valid_o, !(status_o && last_pixel_o), "error result flagged as last pixel")

endmodule

`default_nettype wire

/* test/frame_flip_rotate_invert_tb.sv */
// Self-checking testbench for frame_flip_rotate_invert: loads frames, fetches them back
// through every transform and compares each result beat against a predicted pixel.
// Depends on ffri_pkg and the frame_flip_rotate_invert RTL only.
`timescale 1ns / 1ps

module frame_flip_rotate_invert_tb import ffri_pkg::*;;

  localparam int unsigned MaxDim       = 256;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned TargetBeats  = 1050;
  localparam int unsigned TimeoutNs    = 5_000_000;

  localparam logic [ModeW-1:0] MODE_SPARE     = 3'd7;  // unused code, acts as invert
  localparam logic             PIX_OK         = 1'b0;
  localparam logic             PIX_NOT_LOADED = 1'b1;

  typedef struct packed {
    logic             act;
    logic [ByteW-1:0] first;
    logic [ByteW-1:0] second;
    logic [ByteW-1:0] third;
  } beat_t;

  typedef struct packed {
    logic [ByteW-1:0] first;
    logic [ByteW-1:0] second;
    logic [ByteW-1:0] third;
    logic             last;
    logic             status;
  } pixel_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = CFG_MODE;
  logic [CfgDataW-1:0] cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic                action_i     = ACT_LOAD;
  logic [ByteW-1:0]    in_first_i   = '0;
  logic [ByteW-1:0]    in_second_i  = '0;
  logic [ByteW-1:0]    in_third_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [ByteW-1:0]    out_first_o;
  logic [ByteW-1:0]    out_second_o;
  logic [ByteW-1:0]    out_third_o;
  logic                last_pixel_o;
  logic                status_o;

  frame_flip_rotate_invert #(
    .MAX_DIM(MaxDim)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .in_first_i  (in_first_i),
    .in_second_i (in_second_i),
    .in_third_i  (in_third_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_first_o (out_first_o),
    .out_second_o(out_second_o),
    .out_third_o (out_third_o),
    .last_pixel_o(last_pixel_o),
    .status_o    (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: registers, frame store and counters
  logic [ModeW-1:0]   reg_mode   = MODE_INVERT;
  logic [DimRegW-1:0] reg_width  = DIM_RESET;
  logic [DimRegW-1:0] reg_height = DIM_RESET;
  logic               reg_color  = 1'b0;
  logic [PixW-1:0]    frame_mem [MaxDim*MaxDim];
  int unsigned        load_row    = 0;
  int unsigned        load_col    = 0;
  int unsigned        fetch_outer = 0;
  int unsigned        fetch_inner = 0;
  logic               frame_full  = 1'b0;

  beat_t       beat_q[$];
  pixel_t      want_pixels_q[$];
  int unsigned beat_count     = 0;
  int unsigned mismatch_cnt   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  function automatic int unsigned eff_dim(input logic [DimRegW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  function automatic logic rotating(input logic [ModeW-1:0] m);
    return (m == MODE_CW || m == MODE_CCW);
  endfunction

  // Apply one accepted beat to the predictor; a fetch queues the pixel it yields.
  function automatic void orient_pixel(input logic act, input logic [ByteW-1:0] b0,
                                       input logic [ByteW-1:0] b1, input logic [ByteW-1:0] b2);
    int unsigned      w, h, outer_lim, inner_lim, o, i, r, c;
    logic [ModeW-1:0] m;
    logic [PixW-1:0]  px;
    pixel_t           res;
    w = eff_dim(reg_width);
    h = eff_dim(reg_height);
    res = '0;
    if (act == ACT_LOAD) begin
      if (!frame_full) begin
        if (load_row < h && load_col < w)
          frame_mem[load_row*MaxDim + load_col] = reg_color ? {b2, b1, b0} : {16'h0, b0};
        load_col++;
        if (load_col >= w) begin
          load_col = 0;
          load_row++;
          if (load_row >= h) frame_full = 1'b1;
        end
      end
    end else if (!frame_full) begin
      res.status = PIX_NOT_LOADED;
      want_pixels_q.push_back(res);
    end else begin
      m = (reg_mode > MODE_CCW) ? MODE_INVERT : reg_mode;
      outer_lim = rotating(m) ? w : h;
      inner_lim = rotating(m) ? h : w;
      // clamp counters left beyond the bounds by a register change
      o = (fetch_outer < outer_lim) ? fetch_outer : outer_lim - 1;
      i = (fetch_inner < inner_lim) ? fetch_inner : inner_lim - 1;
      case (m)
        MODE_HFLIP: begin r = o;         c = w - 1 - i; end
        MODE_VFLIP: begin r = h - 1 - o; c = i;         end
        MODE_CW:    begin r = h - 1 - i; c = o;         end
        MODE_CCW:   begin r = i;         c = w - 1 - o; end
        default:    begin r = o;         c = i;         end
      endcase
      px = frame_mem[r*MaxDim + c];
      if (m == MODE_INVERT) px = ~px;
      res.first  = px[7:0];
      res.second = reg_color ? px[15:8] : '0;
      res.third  = reg_color ? px[23:16] : '0;
      res.status = PIX_OK;
      fetch_inner = i + 1;
      fetch_outer = o;
      if (fetch_inner >= inner_lim) begin
        fetch_inner = 0;
        fetch_outer = o + 1;
        if (fetch_outer >= outer_lim) res.last = 1'b1;
      end
      if (res.last) begin
        load_row    = 0;
        load_col    = 0;
        fetch_outer = 0;
        fetch_inner = 0;
        frame_full  = 1'b0;
      end
      want_pixels_q.push_back(res);
    end
  endfunction

  // Driver: present the next queued beat, hold it until accepted.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    beat_t nxt;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      action_i    <= ACT_LOAD;
      in_first_i  <= '0;
      in_second_i <= '0;
      in_third_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o)
        orient_pixel(action_i, in_first_i, in_second_i, in_third_i);
      if (!in_valid_i || in_ready_o) begin
        if (beat_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = beat_q.pop_front();
          in_valid_i  <= 1'b1;
          action_i    <= nxt.act;
          in_first_i  <= nxt.first;
          in_second_i <= nxt.second;
          in_third_i  <= nxt.third;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest predicted pixel.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pixel_t got, want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = {out_first_o, out_second_o, out_third_o, last_pixel_o, status_o};
        if (want_pixels_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: unexpected result %h %h %h last %b status %b", $realtime,
                     got.first, got.second, got.third, got.last, got.status);
          mismatch_cnt++;
        end else begin
          want = want_pixels_q.pop_front();
          if (got.first !== want.first || got.second !== want.second ||
              got.third !== want.third || got.last !== want.last ||
              got.status !== want.status) begin
            if (mismatch_cnt < 10)
              $display({"%0t: pixel mismatch exp %h %h %h last %b status %b, ",
                        "got %h %h %h last %b status %b"},
                       $realtime, want.first, want.second, want.third, want.last,
                       want.status, got.first, got.second, got.third, got.last,
                       got.status);
            mismatch_cnt++;
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic push_pixel(input logic act, input logic [ByteW-1:0] b0,
                            input logic [ByteW-1:0] b1, input logic [ByteW-1:0] b2);
    beat_q.push_back('{act: act, first: b0, second: b1, third: b2});
    beat_count++;
  endtask

  task automatic push_beat(input logic act);
    push_pixel(act, ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)),
               ByteW'($urandom_range(0, 255)));
  endtask

  // Hold until every beat is accepted and every result is back, then let the block settle.
  task automatic wait_idle();
    @(negedge clk_i);
    while (beat_q.size() != 0 || in_valid_i || want_pixels_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MODE:   reg_mode   = data[ModeW-1:0];
      CFG_WIDTH:  reg_width  = data[DimRegW-1:0];
      CFG_HEIGHT: reg_height = data[DimRegW-1:0];
      default:    reg_color  = data[0];
    endcase
  endtask

  // Rotate through the idling phases frame by frame.
  task automatic pick_idling(input int unsigned phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  // One frame: loads with stray early fetches, maybe ignored extra loads, then fetches.
  // Sometimes swap mode and color mid-fetch, keeping the same scan shape.
  task automatic run_frame();
    int unsigned      total, cut;
    logic [ModeW-1:0] next_mode;
    total = eff_dim(reg_width) * eff_dim(reg_height);
    for (int unsigned k = 0; k < total; k++) begin
      if ($urandom_range(0, 24) == 0) push_beat(ACT_FETCH);
      push_beat(ACT_LOAD);
    end
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) push_beat(ACT_LOAD);
    cut = total;
    if (total > 1 && $urandom_range(0, 5) == 0) cut = $urandom_range(1, total - 1);
    repeat (cut) push_beat(ACT_FETCH);
    if (cut < total) begin
      wait_idle();
      do next_mode = ModeW'($urandom_range(0, 7));
      while (rotating(next_mode) != rotating(reg_mode));
      write_reg(CFG_MODE, CfgDataW'(next_mode));
      write_reg(CFG_COLOR, CfgDataW'($urandom_range(0, 1)));
      repeat (total - cut) push_beat(ACT_FETCH);
    end
  endtask

  initial begin : stimulus
    int unsigned frame_idx;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: fetch before load, then a partial 256-wide load cut short by shrinking
    push_pixel(ACT_FETCH, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(ACT_LOAD, 8'h00, 8'hAA, 8'h55);
    push_pixel(ACT_LOAD, 8'hFF, 8'h12, 8'h34);
    push_pixel(ACT_LOAD, 8'h5A, 8'hFF, 8'hFF);
    wait_idle();
    write_reg(CFG_WIDTH, 9'd2);
    write_reg(CFG_HEIGHT, '0);
    push_pixel(ACT_LOAD, 8'h77, 8'h77, 8'h77);   // out of bounds, wraps and completes
    push_pixel(ACT_LOAD, 8'h88, 8'h99, 8'hAA);   // frame full: dropped
    push_pixel(ACT_FETCH, 8'h00, 8'h00, 8'h00);
    push_pixel(ACT_FETCH, 8'h00, 8'h00, 8'h00);
    push_pixel(ACT_FETCH, 8'h00, 8'h00, 8'h00);  // counters restarted: not loaded
    wait_idle();

    // Directed: RGB 3x2, mirrored fetch switched to clockwise mid-frame
    write_reg(CFG_COLOR, 9'd1);
    write_reg(CFG_WIDTH, 9'd3);
    write_reg(CFG_HEIGHT, 9'd2);
    write_reg(CFG_MODE, CfgDataW'(MODE_HFLIP));
    push_pixel(ACT_LOAD, 8'h00, 8'h00, 8'h00);
    push_pixel(ACT_LOAD, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(ACT_LOAD, 8'hFF, 8'h00, 8'h80);
    push_pixel(ACT_LOAD, 8'h01, 8'hFE, 8'h7F);
    push_pixel(ACT_LOAD, 8'h80, 8'h01, 8'hFF);
    push_pixel(ACT_LOAD, 8'h3C, 8'hC3, 8'h00);
    repeat (2) push_pixel(ACT_FETCH, 8'h00, 8'h00, 8'h00);
    wait_idle();
    write_reg(CFG_MODE, CfgDataW'(MODE_CW));
    repeat (5) push_pixel(ACT_FETCH, 8'hFF, 8'hFF, 8'hFF);
    wait_idle();
    write_reg(CFG_MODE, CfgDataW'(MODE_SPARE));

    // Random frames, mostly small; one full-width frame with clamped dimensions
    frame_idx = 0;
    while (beat_count < TargetBeats) begin
      pick_idling(frame_idx);
      if (frame_idx == 2) begin
        write_reg(CFG_WIDTH, 9'h1FF);
        write_reg(CFG_HEIGHT, '0);
      end else begin
        write_reg(CFG_WIDTH, CfgDataW'($urandom_range(0, 9)));
        write_reg(CFG_HEIGHT, CfgDataW'($urandom_range(0, 9)));
      end
      write_reg(CFG_MODE, CfgDataW'($urandom_range(0, 7)));
      write_reg(CFG_COLOR, CfgDataW'($urandom_range(0, 1)));
      run_frame();
      wait_idle();
      frame_idx++;
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && want_pixels_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/ffri_pkg.sv
src/ffri_ctrl.sv
src/ffri_dp.sv
src/frame_flip_rotate_invert.sv
test/frame_flip_rotate_invert_tb.sv
